[rtl/dot_plot_raster_buffer_macros.svh]
// Assertion macros used by the raster buffer datapath RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DOT_PLOT_RASTER_BUFFER_MACROS_SVH
`define DOT_PLOT_RASTER_BUFFER_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define DPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DPR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dpr_pkg.sv]
// Package for the dot plot raster buffer: constants, codes and the
// command/status structs between controller and datapath. No dependencies.
package dpr_pkg;

	localparam int DPR_ROWS          = 64;
	localparam int DPR_BYTES_PER_ROW = 128;

	localparam logic [7:0] PLOT_BASE = 8'h40;
	localparam logic [7:0] TERM_A    = 8'h05;
	localparam logic [7:0] TERM_B    = 8'h0A;

	// x / 6 as (x * 683) >> 12, exact for x below 2048
	localparam int DOTS_PER_BYTE = 6;
	localparam int RECIP_6       = 683;
	localparam int RECIP_SHIFT   = 12;

	localparam logic CMD_PLOT  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} dpr_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} dpr_sts_t;

endpackage

[rtl/dpr_if.sv]
// Request and result channel interfaces of the dot plot raster buffer.
// Valid/ready handshake; no package dependency.
interface dpr_req_if;
	logic              valid;
	logic              ready;
	logic              command;
	logic [7:0]        row;
	logic signed [10:0] dot_column;

	modport source (output valid, command, row, dot_column, input ready);
	modport sink   (input valid, command, row, dot_column, output ready);
endinterface

interface dpr_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  out_byte;
	logic        last_of_row;
	logic        last_of_frame;
	logic        out_of_bounds;
	logic [15:0] error_count;

	modport source (output valid, kind, out_byte, last_of_row, last_of_frame,
		out_of_bounds, error_count, input ready);
	modport sink   (input valid, kind, out_byte, last_of_row, last_of_frame,
		out_of_bounds, error_count, output ready);
endinterface

[rtl/dot_plot_raster_buffer.sv]
// Top level of the dot plot raster buffer: controller plus datapath.
// Depends on dpr_pkg, dpr_if, dpr_ctrl and dpr_dp.
//
//   channel   dir   handshake       payload
//   request   in    valid/ready     command, row, dot_column
//   result    out   valid/ready     kind, out_byte, last_of_row, last_of_frame,
//                                   out_of_bounds, error_count
//
// Each request is handled in order: accept and divide the column by six, read the
// dot and row maximum memories, then read-modify-write and load the result.
// After reset a clearing pass writes all ROWS * 2**clog2(BYTES_PER_ROW) entries (8192 by
// default) and zeroes both memories; request.ready stays low until it ends.
// The execute step waits while the result register holds an untaken result.
module dot_plot_raster_buffer import dpr_pkg::*; #(
	parameter int ROWS          = DPR_ROWS,
	parameter int BYTES_PER_ROW = DPR_BYTES_PER_ROW
) (
	input  logic         clk,
	input  logic         arst_n,
	dpr_req_if.sink      request,
	dpr_res_if.source    result
);

	dpr_cmd_t cmd;
	dpr_sts_t sts;

	dpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dpr_dp #(
		.ROWS          (ROWS),
		.BYTES_PER_ROW (BYTES_PER_ROW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.command       (request.command),
		.row           (request.row),
		.dot_column    (request.dot_column),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.kind          (result.kind),
		.out_byte      (result.out_byte),
		.last_of_row   (result.last_of_row),
		.last_of_frame (result.last_of_frame),
		.out_of_bounds (result.out_of_bounds),
		.error_count   (result.error_count)
	);

endmodule

[rtl/dpr_ctrl.sv]
// Controller of the raster buffer: clearing pass, accept, read, execute.
// Depends on dpr_pkg for the command and status structs.
module dpr_ctrl import dpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dpr_sts_t sts,
	output dpr_cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd.clear = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				// hold until the result register is free
				if (!sts.out_busy) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/dpr_dp.sv]
// Datapath of the raster buffer: dot memory, row maximum memory, drain
// position, reject counter and result register. Depends on dpr_pkg.
`include "dot_plot_raster_buffer_macros.svh"

module dpr_dp import dpr_pkg::*; #(
	parameter int ROWS          = DPR_ROWS,
	parameter int BYTES_PER_ROW = DPR_BYTES_PER_ROW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dpr_cmd_t          cmd,
	output dpr_sts_t          sts,
	input  logic              command,
	input  logic [7:0]        row,
	input  logic signed [10:0] dot_column,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              kind,
	output logic [7:0]        out_byte,
	output logic              last_of_row,
	output logic              last_of_frame,
	output logic              out_of_bounds,
	output logic [15:0]       error_count
);

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = $clog2(BYTES_PER_ROW);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = ROWS * (2 ** COL_W);

	// decode of the incoming request
	logic [9:0]  mag;
	logic [21:0] prod;
	logic [9:0]  quot;
	logic [11:0] quot6;
	logic [2:0]  rem;
	logic        reject_d;

	logic             cmd_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [2:0]       bit_q;
	logic             reject_q;

	logic [ROW_W-1:0] drain_row_q;
	logic [COL_W-1:0] drain_col_q;
	logic [15:0]      rej_q;
	logic [ADDR_W-1:0] clr_q;

	logic [5:0]       dot_mem [DEPTH];
	logic [COL_W-1:0] max_mem [ROWS];
	logic [5:0]       dot_rd_q;
	logic [COL_W-1:0] max_rd_q;

	logic [ROW_W-1:0]  rd_row;
	logic [COL_W-1:0]  rd_col;
	logic [ADDR_W-1:0] rd_addr;

	logic              dot_we;
	logic [ADDR_W-1:0] dot_wa;
	logic [5:0]        dot_wd;
	logic              max_we;
	logic [ROW_W-1:0]  max_wa;
	logic [COL_W-1:0]  max_wd;

	logic             is_drain;
	logic             col_in_row;
	logic             col_at_term;
	logic             frame_end;
	logic [5:0]       bit_mask;
	logic [15:0]      rej_d;
	logic [ROW_W-1:0] drain_row_d;
	logic [COL_W-1:0] drain_col_d;

	logic        out_valid_q;
	logic        kind_d;
	logic [7:0]  byte_d;
	logic        lor_d;
	logic        lof_d;
	logic        oob_d;

	assign mag      = dot_column[9:0];
	assign prod     = 22'(mag) * 22'(RECIP_6);
	assign quot     = prod[21:RECIP_SHIFT];
	assign quot6    = {quot, 2'b00} + {1'b0, quot, 1'b0};
	assign rem      = 3'(mag - quot6[9:0]);
	assign reject_d = dot_column[10] || (11'(row) >= 11'(ROWS)) ||
		(quot > 10'(BYTES_PER_ROW - 3));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			row_q    <= ROW_W'(row);
			col_q    <= COL_W'(quot);
			bit_q    <= rem;
			reject_q <= reject_d;
		end
	end

	assign is_drain = (cmd_q == CMD_DRAIN);
	assign rd_row   = is_drain ? drain_row_q : row_q;
	assign rd_col   = is_drain ? drain_col_q : col_q;
	assign rd_addr  = {rd_row, rd_col};

	always_ff @(posedge clk) begin
		if (dot_we) begin
			dot_mem[dot_wa] <= dot_wd;
		end
		dot_rd_q <= dot_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (max_we) begin
			max_mem[max_wa] <= max_wd;
		end
		max_rd_q <= max_mem[rd_row];
	end

	assign col_in_row  = (drain_col_q <= max_rd_q);
	assign col_at_term = ({1'b0, drain_col_q} == ({1'b0, max_rd_q} + 1'b1));
	assign frame_end   = (drain_row_q == ROW_W'(ROWS - 1));
	assign bit_mask    = 6'(6'b000001 << bit_q);

	always_comb begin
		dot_we      = 1'b0;
		dot_wa      = rd_addr;
		dot_wd      = '0;
		max_we      = 1'b0;
		max_wa      = rd_row;
		max_wd      = '0;
		rej_d       = rej_q;
		drain_row_d = drain_row_q;
		drain_col_d = drain_col_q;
		kind_d      = KIND_ACK;
		byte_d      = '0;
		lor_d       = 1'b0;
		lof_d       = 1'b0;
		oob_d       = 1'b0;
		if (cmd.clear) begin
			dot_we = 1'b1;
			dot_wa = clr_q;
			max_we = 1'b1;
			max_wa = clr_q[ADDR_W-1:COL_W];
		end else if (cmd.exec) begin
			if (!is_drain) begin
				if (reject_q) begin
					oob_d = 1'b1;
					if (rej_q != 16'hFFFF) begin
						rej_d = rej_q + 16'd1;
					end
				end else begin
					dot_we = 1'b1;
					dot_wd = dot_rd_q | bit_mask;
					if (col_q > max_rd_q) begin
						max_we = 1'b1;
						max_wd = col_q;
					end
				end
			end else begin
				kind_d = KIND_DATA;
				priority if (col_in_row) begin
					// read and clear the stored byte
					byte_d      = PLOT_BASE | {2'b00, dot_rd_q};
					dot_we      = 1'b1;
					drain_col_d = drain_col_q + 1'b1;
				end else if (col_at_term) begin
					byte_d      = TERM_A;
					drain_col_d = drain_col_q + 1'b1;
				end else begin
					byte_d      = TERM_B;
					lor_d       = 1'b1;
					lof_d       = frame_end;
					max_we      = 1'b1;
					drain_col_d = '0;
					drain_row_d = frame_end ? '0 : drain_row_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rej_q       <= '0;
			drain_row_q <= '0;
			drain_col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			rej_q       <= rej_d;
			drain_row_q <= drain_row_d;
			drain_col_q <= drain_col_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kind          <= kind_d;
			out_byte      <= byte_d;
			last_of_row   <= lor_d;
			last_of_frame <= lof_d;
			out_of_bounds <= oob_d;
			error_count   <= rej_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.out_busy   = out_valid_q && !out_ready;

	`DPR_ASSERT(a_exec_slot_free, cmd.exec |-> !out_valid_q, "execute with result held")
	`DPR_ASSERT(a_count_mono, 1'b1 |=> rej_q >= $past(rej_q), "reject count went down")
	`DPR_ASSERT(a_drain_row_rng, {1'b0, drain_row_q} < (ROW_W + 1)'(ROWS), "drain row out of range")
	`DPR_ASSERT(a_drain_col_rng, {1'b0, drain_col_q} < (COL_W + 1)'(BYTES_PER_ROW), "drain column out of range")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dot_plot_raster_buffer: a directed table, random plot and
// drain requests, and a burst of rejected points followed by more random requests, all scored in order.
// Depends on dpr_pkg, dpr_if and the raster buffer RTL.
module testbench;
	import dpr_pkg::*;

	localparam int ROWS         = DPR_ROWS;
	localparam int BPR          = DPR_BYTES_PER_ROW;
	localparam int LAST_BYTE    = BPR - 3;
	localparam int LIMIT        = 1_500_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 1000;
	localparam int SETTLE       = 40;

	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic        last_of_row;
		logic        last_of_frame;
		logic        out_of_bounds;
		logic [15:0] error_count;
	} raster_result_t;

	typedef struct packed {
		logic           command;
		logic [7:0]     row;
		logic [10:0]    dot_column;
		logic           typed;
		raster_result_t want;
	} plan_step_t;

	localparam raster_result_t NO_RESULT = '0;

	localparam plan_step_t PLAN [22] = '{
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b1, '{KIND_DATA, PLOT_BASE, 1'b0, 1'b0, 1'b0, 16'd0}},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b1, '{KIND_DATA, TERM_A,    1'b0, 1'b0, 1'b0, 16'd0}},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b1, '{KIND_DATA, TERM_B,    1'b1, 1'b0, 1'b0, 16'd0}},
		// columns -1 and -1024
		'{CMD_PLOT,  8'd0,   11'h7FF, 1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd1}},
		'{CMD_PLOT,  8'd0,   11'h400, 1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd2}},
		'{CMD_PLOT,  8'd0,   11'd1023, 1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd3}},
		'{CMD_PLOT,  8'd0,   11'd756, 1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd4}},
		'{CMD_PLOT,  8'd64,  11'd0,   1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd5}},
		'{CMD_PLOT,  8'd255, 11'd0,   1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd6}},
		'{CMD_PLOT,  8'd128, 11'd0,   1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 16'd7}},
		'{CMD_PLOT,  8'd63,  11'd755, 1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b0, 16'd7}},
		'{CMD_PLOT,  8'd1,   11'd0,   1'b1, '{KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b0, 16'd7}},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT},
		// land behind and ahead of the drain position in the row being drained
		'{CMD_PLOT,  8'd1,   11'd1,   1'b0, NO_RESULT},
		'{CMD_PLOT,  8'd1,   11'd11,  1'b0, NO_RESULT},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT},
		'{CMD_PLOT,  8'd2,   11'd5,   1'b0, NO_RESULT},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT},
		'{CMD_DRAIN, 8'd0,   11'd0,   1'b0, NO_RESULT}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	dpr_req_if req_ch ();
	dpr_res_if res_ch ();

	dot_plot_raster_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch)
	);

	bit [5:0]  shadow_dots [ROWS][BPR];
	int        shadow_row_max [ROWS];
	bit [15:0] shadow_rejects;
	int        shadow_drain_row;
	int        shadow_drain_col;

	raster_result_t awaited_results [$];
	int             failures;
	int             cycle_count;
	bit             send_gaps;
	bit             take_gaps;
	bit             hold_results;

	function automatic raster_result_t predict_raster(logic cmd, logic [7:0] row,
		logic [10:0] col);
		raster_result_t res;
		int byte_idx;
		int bit_idx;
		int r;
		int m;
		int c;
		res = '0;
		if (cmd == CMD_PLOT) begin
			byte_idx = int'(col) / DOTS_PER_BYTE;
			bit_idx  = int'(col) % DOTS_PER_BYTE;
			res.kind = KIND_ACK;
			if (col[10] || int'(row) >= ROWS || byte_idx > LAST_BYTE) begin
				if (shadow_rejects != 16'hFFFF)
					shadow_rejects++;
				res.out_of_bounds = 1'b1;
			end else begin
				shadow_dots[row][byte_idx][bit_idx] = 1'b1;
				if (byte_idx > shadow_row_max[row])
					shadow_row_max[row] = byte_idx;
			end
		end else begin
			r = shadow_drain_row;
			m = shadow_row_max[r];
			c = shadow_drain_col;
			res.kind = KIND_DATA;
			if (c <= m && c < BPR) begin
				res.out_byte = PLOT_BASE | {2'b00, shadow_dots[r][c]};
				shadow_dots[r][c] = '0;
				shadow_drain_col = c + 1;
			end else if (c == m + 1) begin
				res.out_byte = TERM_A;
				shadow_drain_col = c + 1;
			end else begin
				res.out_byte      = TERM_B;
				res.last_of_row   = 1'b1;
				res.last_of_frame = (r == ROWS - 1);
				shadow_row_max[r] = 0;
				shadow_drain_col  = 0;
				shadow_drain_row  = (r == ROWS - 1) ? 0 : r + 1;
			end
		end
		res.error_count = shadow_rejects;
		return res;
	endfunction

	// Call at a falling edge; returns at a falling edge with valid still high, or low after a random gap.
	task automatic offer(input logic cmd, input logic [7:0] row, input logic [10:0] col,
		input logic typed, input raster_result_t want);
		raster_result_t predicted;
		req_ch.valid      <= 1'b1;
		req_ch.command    <= cmd;
		req_ch.row        <= row;
		req_ch.dot_column <= col;
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_raster(cmd, row, col);
		awaited_results.push_back(typed ? want : predicted);
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic random_request();
		int          pick;
		logic [7:0]  row;
		logic [10:0] col;
		pick = $urandom_range(0, 99);
		row  = 8'($urandom);
		col  = 11'($urandom);
		if (pick < 62) begin
			offer(CMD_DRAIN, row, col, 1'b0, NO_RESULT);
		end else if (pick < 90) begin
			// plot in or just ahead of the row being drained
			row = 8'((shadow_drain_row + $urandom_range(0, 3)) % ROWS);
			if ($urandom_range(0, 15) == 0)
				col = 11'($urandom_range(0, LAST_BYTE * DOTS_PER_BYTE + DOTS_PER_BYTE - 1));
			else
				col = 11'($urandom_range(0, 23));
			offer(CMD_PLOT, row, col, 1'b0, NO_RESULT);
		end else begin
			offer(CMD_PLOT, row, col, 1'b0, NO_RESULT);
		end
	endtask

	initial begin
		int n;
		req_ch.valid      = 1'b0;
		req_ch.command    = CMD_PLOT;
		req_ch.row        = '0;
		req_ch.dot_column = '0;
		send_gaps         = 1'b0;
		take_gaps         = 1'b0;
		hold_results      = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		foreach (PLAN[i])
			offer(PLAN[i].command, PLAN[i].row, PLAN[i].dot_column, PLAN[i].typed,
				PLAN[i].want);
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n % 100 == 0) begin
				send_gaps = ($urandom_range(0, 2) != 0);
				take_gaps = ($urandom_range(0, 2) != 0);
				if (n == 300)
					hold_results = 1'b1;
			end
			random_request();
			n++;
		end
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		// reject negative columns on legal rows
		repeat (4)
			offer(CMD_PLOT, 8'($urandom_range(0, ROWS - 1)), 11'h400 | 11'($urandom), 1'b0,
				NO_RESULT);
		repeat (40)
			random_request();
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int stall;
		int held;
		stall = 0;
		held  = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				res_ch.ready <= 1'b0;
				held++;
				if (held == HOLD_CYCLES) begin
					hold_results = 1'b0;
					held = 0;
				end
			end else if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else if (take_gaps && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 12);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		raster_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with nothing pending: kind %0d out_byte %h",
					res_ch.kind, res_ch.out_byte);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				if (res_ch.kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, res_ch.kind);
					failures++;
				end
				if (res_ch.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, actual %h", want.out_byte, res_ch.out_byte);
					failures++;
				end
				if (res_ch.last_of_row !== want.last_of_row) begin
					$error("last_of_row: expected %0d, actual %0d", want.last_of_row,
						res_ch.last_of_row);
					failures++;
				end
				if (res_ch.last_of_frame !== want.last_of_frame) begin
					$error("last_of_frame: expected %0d, actual %0d", want.last_of_frame,
						res_ch.last_of_frame);
					failures++;
				end
				if (res_ch.out_of_bounds !== want.out_of_bounds) begin
					$error("out_of_bounds: expected %0d, actual %0d", want.out_of_bounds,
						res_ch.out_of_bounds);
					failures++;
				end
				if (res_ch.error_count !== want.error_count) begin
					$error("error_count: expected %0d, actual %0d", want.error_count,
						res_ch.error_count);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
